// ===== rtl/sis_pkg.sv =====
// Package for the sorted identifier set: sizes, command codes, state and cell control types.
package sis_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int POS_W    = 8;
    localparam int ECNT_W   = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_COMMIT
    } state_t;

    // Control that the sequencer broadcasts to every cell of the row.
    typedef struct packed {
        logic cmp;
        logic ins;
    } cell_ctrl_t;

endpackage

// ===== rtl/sis_if.sv =====
// Handshake interfaces for the command and response channels.
interface sis_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] key;
    logic [7:0]  position;

    modport source (output valid, output command, output key, output position, input ready);
    modport sink   (input valid, input command, input key, input position, output ready);
endinterface

interface sis_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        found;
    logic [31:0] read_value;
    logic [6:0]  entry_count;

    modport source (output valid, output status, output found, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found, input read_value,
                    input entry_count, output ready);
endinterface

// ===== rtl/sis_cell.sv =====
// One cell of the sorted row: holds a key, compares it and shifts from its lower neighbor.
module sis_cell
    import sis_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] cmd_key,
    input  logic             occ,
    input  logic             hit,
    input  logic [KEY_W-1:0] prev_key,
    input  logic             prev_mark,
    output logic [KEY_W-1:0] key,
    output logic             mark,
    output logic             eq,
    output logic [KEY_W-1:0] sel
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic             mark_reg, mark_next;
    logic             eq_reg, eq_next;
    logic [KEY_W-1:0] sel_reg, sel_next;

    // The mark flags every cell at or above the insertion point; the lowest
    // marked cell takes the new key and the others take their neighbor's key.
    always_comb
    begin
        key_next  = key_reg;
        mark_next = mark_reg;
        eq_next   = eq_reg;
        sel_next  = sel_reg;
        if (ctrl.cmp)
        begin
            mark_next = !occ || (key_reg >= cmd_key);
            eq_next   = occ && (key_reg == cmd_key);
            sel_next  = hit ? key_reg : '0;
        end
        if (ctrl.ins && mark_reg)
        begin
            key_next = prev_mark ? prev_key : cmd_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        mark_reg <= mark_next;
        eq_reg   <= eq_next;
        sel_reg  <= sel_next;
    end

    assign key  = key_reg;
    assign mark = mark_reg;
    assign eq   = eq_reg;
    assign sel  = sel_reg;

endmodule

// ===== rtl/sorted_id_set.sv =====
// Top level of the sorted identifier set: command sequencer, cell row and response register.
//
//  Channel | Direction | Payload
//  cmd     | in        | command, key, position
//  rsp     | out       | status, found, read_value, entry_count
//
// A command is handled in order: the sequencer accepts the transfer, then every cell
// compares its key in parallel, then the row commits an insert and the response
// register is loaded. Reset clears the key count, the sequencer and the response valid;
// cell keys are not reset, since a key is only read below the count. A stalled
// response holds the sequencer in its commit cycle; a new command is still accepted
// while a finished response waits to be taken.
module sorted_id_set
    import sis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sis_cmd_if.sink    cmd,
    sis_rsp_if.source  rsp
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        code_reg, code_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic              found_reg, found_next;
    logic [KEY_W-1:0]  value_reg, value_next;
    logic [ECNT_W-1:0] ecount_reg, ecount_next;

    logic              out_free;
    logic              cmd_ready;
    logic              cmp_en;
    logic              commit_go;
    logic              ins_go;
    logic              dup;
    logic              full;
    logic [KEY_W-1:0]  sel_or;
    cell_ctrl_t        ctrl;

    logic [KEY_W-1:0]  cell_key  [CAPACITY];
    logic [KEY_W-1:0]  cell_sel  [CAPACITY];
    logic [CAPACITY-1:0] cell_mark;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_occ;
    logic [CAPACITY-1:0] cell_hit;

    assign out_free = !out_valid_reg || rsp.ready;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_ready = 1'b0;
        cmp_en    = 1'b0;
        commit_go = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_CMP:
            begin
                cmp_en = 1'b1;
            end
            ST_COMMIT:
            begin
                commit_go = out_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign cmd.ready = cmd_ready;

    // The flags of the compare cycle are registered in the cells, so the reductions
    // below only see one-bit flags and pre-masked keys.
    assign dup    = |cell_eq;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign ins_go = commit_go && (code_reg == CMD_INSERT) && !dup && !full;

    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_or = sel_or | cell_sel[i];
        end
    end

    assign ctrl.cmp = cmp_en;
    assign ctrl.ins = ins_go;

    // Row of cells. Cell i holds the key at sorted position i while i is below the count.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_occ[i] = (32'(i) < 32'(count_reg));
        assign cell_hit[i] = (32'(pos_reg) == 32'(i)) && cell_occ[i];

        if (i == 0)
        begin : g_first
            sis_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .cmd_key   (key_reg),
                .occ       (cell_occ[i]),
                .hit       (cell_hit[i]),
                .prev_key  ('0),
                .prev_mark (1'b0),
                .key       (cell_key[i]),
                .mark      (cell_mark[i]),
                .eq        (cell_eq[i]),
                .sel       (cell_sel[i])
            );
        end
        else
        begin : g_rest
            sis_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .cmd_key   (key_reg),
                .occ       (cell_occ[i]),
                .hit       (cell_hit[i]),
                .prev_key  (cell_key[i-1]),
                .prev_mark (cell_mark[i-1]),
                .key       (cell_key[i]),
                .mark      (cell_mark[i]),
                .eq        (cell_eq[i]),
                .sel       (cell_sel[i])
            );
        end
    end

    // Command capture, count update and response register.
    always_comb
    begin
        code_next      = code_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        value_next     = value_reg;
        ecount_next    = ecount_reg;

        if (cmd.valid && cmd_ready)
        begin
            code_next = cmd.command;
            key_next  = cmd.key;
            pos_next  = cmd.position;
        end

        if (ins_go)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (commit_go)
        begin
            out_valid_next = 1'b1;
            status_next    = (code_reg == CMD_INSERT) && !dup && full;
            found_next     = (code_reg == CMD_QUERY) && dup;
            value_next     = (code_reg == CMD_READ) ? sel_or : '0;
            ecount_next    = ECNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        ecount_reg <= ecount_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.read_value  = value_reg;
    assign rsp.entry_count = ecount_reg;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // A committed insert grows the count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_go |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the count");

    // A new response is only loaded from the commit cycle.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("response loaded outside commit");

    // A refused insert and a found flag never appear in the same response.
    a_rsp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(status_reg && found_reg))
        else $error("status and found both set");

    // No command is taken while the sequencer is in its compare state.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> !cmd.ready)
        else $error("command accepted during compare");

endmodule
